// File: rtl/tvenv_pkg.sv
// Shared types, constants and lookup tables for the three-voice envelope block.
`default_nettype none
package tvenv_pkg;

    // Fixed-point layout of the envelope levels (unsigned 4.24).
    localparam int NUM_VOICES      = 3;
    localparam int LEVEL_FRAC_BITS = 24;
    localparam int LEVEL_W         = 28;
    localparam int STEP_W          = 25;
    localparam int CPS_W           = 24;
    localparam int ADDR_W          = 5;
    localparam int DATA_W          = 8;
    localparam int VIDX_W          = 2;
    localparam int RECIP_W         = 30;
    localparam int SHIFT_W         = 6;

    localparam logic [CPS_W-1:0] CPS_RESET = CPS_W'(1464161);

    // Full scale is 15.0; the release floor stands for 0.1.
    localparam logic [LEVEL_W-1:0] LEVEL_MAX   = LEVEL_W'(15) << LEVEL_FRAC_BITS;
    localparam logic [LEVEL_W-1:0] LEVEL_FLOOR =
        LEVEL_W'((64'd1 << LEVEL_FRAC_BITS) / 64'd10);

    // Register offsets within one voice's block of seven.
    localparam logic [2:0] OFF_CTRL = 3'd4;
    localparam logic [2:0] OFF_AD   = 3'd5;
    localparam logic [2:0] OFF_SR   = 3'd6;
    localparam logic [ADDR_W-1:0] REGS_PER_VOICE = ADDR_W'(7);
    localparam logic [ADDR_W-1:0] REG_LIMIT      = ADDR_W'(21);

    // Input word kinds.
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // Envelope phases.
    typedef enum logic [1:0] {
        PH_ATTACK  = 2'd0,
        PH_DECAY   = 2'd1,
        PH_SUSTAIN = 2'd2,
        PH_RELEASE = 2'd3
    } t_phase;

    // Per-voice command derived from one input word.
    typedef struct packed {
        logic              tick;
        logic              ctrl_we;
        logic              ad_we;
        logic              sr_we;
        logic [DATA_W-1:0] value;
    } t_voice_cmd;

    // Decoded register address.
    typedef struct packed {
        logic              hit;
        logic [VIDX_W-1:0] voice;
        logic [2:0]        off;
    } t_reg_dec;

    // Step size for rate nibble n is floor(16 * cps / period[n]). It is formed as
    // (cps * recip[n]) >> shift[n] with recip[n] = ceil(2^(28+l) / period[n]) and
    // l = ceil(log2(period[n])), which is exact for every 24-bit cps.
    localparam logic [RECIP_W-1:0] RATE_RECIP [16] = '{
        RECIP_W'(((64'd1 << 32) + 64'd8) / 64'd9),
        RECIP_W'(((64'd1 << 33) + 64'd31) / 64'd32),
        RECIP_W'(((64'd1 << 34) + 64'd62) / 64'd63),
        RECIP_W'(((64'd1 << 35) + 64'd94) / 64'd95),
        RECIP_W'(((64'd1 << 36) + 64'd148) / 64'd149),
        RECIP_W'(((64'd1 << 36) + 64'd219) / 64'd220),
        RECIP_W'(((64'd1 << 37) + 64'd266) / 64'd267),
        RECIP_W'(((64'd1 << 37) + 64'd312) / 64'd313),
        RECIP_W'(((64'd1 << 37) + 64'd391) / 64'd392),
        RECIP_W'(((64'd1 << 38) + 64'd976) / 64'd977),
        RECIP_W'(((64'd1 << 39) + 64'd1953) / 64'd1954),
        RECIP_W'(((64'd1 << 40) + 64'd3125) / 64'd3126),
        RECIP_W'(((64'd1 << 40) + 64'd3906) / 64'd3907),
        RECIP_W'(((64'd1 << 42) + 64'd11719) / 64'd11720),
        RECIP_W'(((64'd1 << 43) + 64'd19531) / 64'd19532),
        RECIP_W'(((64'd1 << 43) + 64'd31250) / 64'd31251)
    };

    localparam logic [SHIFT_W-1:0] RATE_SHIFT [16] = '{
        SHIFT_W'(28), SHIFT_W'(29), SHIFT_W'(30), SHIFT_W'(31),
        SHIFT_W'(32), SHIFT_W'(32), SHIFT_W'(33), SHIFT_W'(33),
        SHIFT_W'(33), SHIFT_W'(34), SHIFT_W'(35), SHIFT_W'(36),
        SHIFT_W'(36), SHIFT_W'(38), SHIFT_W'(39), SHIFT_W'(39)
    };

    // Split a register address into voice and offset.
    function automatic t_reg_dec decode_reg(input logic [ADDR_W-1:0] addr);
        t_reg_dec d;
        d.hit = (addr < REG_LIMIT);
        if (addr >= (REGS_PER_VOICE + REGS_PER_VOICE)) begin
            d.voice = VIDX_W'(2);
            d.off   = 3'(addr - (REGS_PER_VOICE + REGS_PER_VOICE));
        end else if (addr >= REGS_PER_VOICE) begin
            d.voice = VIDX_W'(1);
            d.off   = 3'(addr - REGS_PER_VOICE);
        end else begin
            d.voice = VIDX_W'(0);
            d.off   = 3'(addr);
        end
        return d;
    endfunction

endpackage
`default_nettype wire

// File: rtl/tvenv_if.sv
// Valid/ready channel interfaces for the input words and the result words.
`default_nettype none
interface tvenv_in_if;
    logic                           valid;
    logic                           ready;
    logic                           kind;
    logic [tvenv_pkg::ADDR_W-1:0]   reg_address;
    logic [tvenv_pkg::DATA_W-1:0]   write_value;

    modport source (output valid, output kind, output reg_address, output write_value,
                    input ready);
    modport sink   (input valid, input kind, input reg_address, input write_value,
                    output ready);
endinterface

interface tvenv_out_if;
    logic                           valid;
    logic                           ready;
    logic [tvenv_pkg::LEVEL_W-1:0]  level_voice0;
    logic [tvenv_pkg::LEVEL_W-1:0]  level_voice1;
    logic [tvenv_pkg::LEVEL_W-1:0]  level_voice2;
    logic [1:0]                     phase_voice0;
    logic [1:0]                     phase_voice1;
    logic [1:0]                     phase_voice2;

    modport source (output valid, output level_voice0, output level_voice1,
                    output level_voice2, output phase_voice0, output phase_voice1,
                    output phase_voice2, input ready);
    modport sink   (input valid, input level_voice0, input level_voice1,
                    input level_voice2, input phase_voice0, input phase_voice1,
                    input phase_voice2, output ready);
endinterface
`default_nettype wire

// File: rtl/three_voice_adsr_envelope.sv
// Top level of the three-voice envelope block: input register, decode and voices.
`default_nettype none
// Three-voice ADSR envelope generator. Each input word is a register write or one
// sample tick, and each accepted word gives exactly one result word with the three
// levels (unsigned 4.24) and phases as they stand after that word. The block takes
// one word per cycle while result words are taken as they are offered. An accepted
// word goes into the input register; when the result slot is free or being emptied
// it moves into the voice registers, which then offer its result word and hold it
// until it is taken. Step sizes are computed from the chip-cycles-per-sample
// register when the attack/decay or sustain/release register is written, by two
// shared reciprocal multipliers; a later change of that register leaves latched
// steps alone. The chip-cycles-per-sample register is written with i_cfg_we and
// takes effect at the next edge.
module three_voice_adsr_envelope (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [tvenv_pkg::CPS_W-1:0] i_cfg_wdata,
    tvenv_in_if.sink                         i_item,
    tvenv_out_if.source                      o_result
);
    import tvenv_pkg::*;

    logic                r_in_valid;
    logic                r_kind;
    logic [ADDR_W-1:0]   r_addr;
    logic [DATA_W-1:0]   r_value;
    logic                r_out_valid;
    logic [CPS_W-1:0]    r_cps;

    logic                advance;
    logic                in_ready;
    t_reg_dec            dec;
    logic [STEP_W-1:0]   step_hi;
    logic [STEP_W-1:0]   step_lo;
    t_voice_cmd          cmd [NUM_VOICES];
    logic [LEVEL_W-1:0]  level [NUM_VOICES];
    logic [1:0]          phase [NUM_VOICES];

    // Handshake: a word moves on when the result slot is free or being emptied.
    assign advance  = r_in_valid && (!r_out_valid || o_result.ready);
    assign in_ready = !r_in_valid || advance;
    assign i_item.ready = in_ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.valid && in_ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (i_item.valid && in_ready) begin
            r_kind  <= i_item.kind;
            r_addr  <= i_item.reg_address;
            r_value <= i_item.write_value;
        end
    end

    // Result valid flag; the payload lives in the voice registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Clock cycles per sample register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cps <= CPS_RESET;
        end else if (i_cfg_we) begin
            r_cps <= i_cfg_wdata;
        end
    end

    // Step sizes from the high and low nibbles of the written byte.
    tvenv_step u_step_hi (
        .i_cps    (r_cps),
        .i_nibble (r_value[DATA_W-1:4]),
        .o_step   (step_hi)
    );

    tvenv_step u_step_lo (
        .i_cps    (r_cps),
        .i_nibble (r_value[3:0]),
        .o_step   (step_lo)
    );

    // Address decode into one command per voice.
    assign dec = decode_reg(r_addr);

    for (genvar v = 0; v < NUM_VOICES; v++) begin : g_voice
        logic sel;

        assign sel = (r_kind == KIND_WRITE) && dec.hit && (dec.voice == VIDX_W'(v));

        always_comb begin
            cmd[v].tick    = (r_kind == KIND_TICK);
            cmd[v].ctrl_we = sel && (dec.off == OFF_CTRL);
            cmd[v].ad_we   = sel && (dec.off == OFF_AD);
            cmd[v].sr_we   = sel && (dec.off == OFF_SR);
            cmd[v].value   = r_value;
        end

        tvenv_voice u_voice (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (advance),
            .i_cmd     (cmd[v]),
            .i_step_hi (step_hi),
            .i_step_lo (step_lo),
            .o_level   (level[v]),
            .o_phase   (phase[v])
        );
    end

    // Result word.
    assign o_result.valid        = r_out_valid;
    assign o_result.level_voice0 = level[0];
    assign o_result.level_voice1 = level[1];
    assign o_result.level_voice2 = level[2];
    assign o_result.phase_voice0 = phase[0];
    assign o_result.phase_voice1 = phase[1];
    assign o_result.phase_voice2 = phase[2];

endmodule
`default_nettype wire

// File: rtl/tvenv_step.sv
// Rate nibble to step size conversion by reciprocal multiplication.
`default_nettype none
module tvenv_step (
    input  wire logic [tvenv_pkg::CPS_W-1:0]  i_cps,
    input  wire logic [3:0]                   i_nibble,
    output logic      [tvenv_pkg::STEP_W-1:0] o_step
);
    import tvenv_pkg::*;

    localparam int PROD_W = CPS_W + RECIP_W;

    logic [PROD_W-1:0] prod;

    // One multiply by the period's reciprocal, then the fixed shift for that period.
    always_comb begin
        prod   = PROD_W'(i_cps) * PROD_W'(RATE_RECIP[i_nibble]);
        o_step = STEP_W'(prod >> RATE_SHIFT[i_nibble]);
    end

endmodule
`default_nettype wire

// File: rtl/tvenv_voice.sv
// One envelope voice: its registers, gate handling and per-tick phase update.
`default_nettype none
module tvenv_voice (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire tvenv_pkg::t_voice_cmd         i_cmd,
    input  wire logic [tvenv_pkg::STEP_W-1:0]  i_step_hi,
    input  wire logic [tvenv_pkg::STEP_W-1:0]  i_step_lo,
    output logic      [tvenv_pkg::LEVEL_W-1:0] o_level,
    output logic      [1:0]                    o_phase
);
    import tvenv_pkg::*;

    localparam int WIDE_W = LEVEL_W + 1;

    t_phase              r_phase, n_phase;
    logic [LEVEL_W-1:0]  r_level, n_level;
    logic                r_gate, n_gate;
    logic [STEP_W-1:0]   r_attack_step, n_attack_step;
    logic [STEP_W-1:0]   r_decay_step, n_decay_step;
    logic [STEP_W-1:0]   r_release_step, n_release_step;
    logic [3:0]          r_sustain, n_sustain;

    logic [LEVEL_W-1:0]  sus;
    logic [WIDE_W-1:0]   att_sum;
    logic [WIDE_W-1:0]   dec_limit;
    logic [WIDE_W-1:0]   rel_diff;

    // Next state for a tick or a register write.
    always_comb begin
        n_phase        = r_phase;
        n_level        = r_level;
        n_gate         = r_gate;
        n_attack_step  = r_attack_step;
        n_decay_step   = r_decay_step;
        n_release_step = r_release_step;
        n_sustain      = r_sustain;

        sus       = LEVEL_W'(r_sustain) << LEVEL_FRAC_BITS;
        att_sum   = WIDE_W'(r_level) + WIDE_W'(r_attack_step);
        dec_limit = WIDE_W'(sus) + WIDE_W'(r_decay_step);
        rel_diff  = WIDE_W'(r_level) - WIDE_W'(r_release_step);

        if (i_cmd.tick) begin
            unique case (r_phase)
                PH_ATTACK: begin
                    // Clamp at full scale and fall into decay.
                    if (att_sum >= WIDE_W'(LEVEL_MAX)) begin
                        n_level = LEVEL_MAX;
                        n_phase = PH_DECAY;
                    end else begin
                        n_level = LEVEL_W'(att_sum);
                    end
                end
                PH_DECAY: begin
                    // Land exactly on the sustain level instead of undershooting it.
                    if (WIDE_W'(r_level) <= dec_limit) begin
                        n_level = sus;
                        n_phase = PH_SUSTAIN;
                    end else begin
                        n_level = r_level - LEVEL_W'(r_decay_step);
                    end
                end
                PH_SUSTAIN: begin
                    // A changed sustain level sends the voice back to decay.
                    if (r_level != sus) begin
                        n_phase = PH_DECAY;
                    end
                end
                PH_RELEASE: begin
                    // Release never goes below the floor.
                    if ((WIDE_W'(r_level) < WIDE_W'(r_release_step)) ||
                        (rel_diff < WIDE_W'(LEVEL_FLOOR))) begin
                        n_level = LEVEL_FLOOR;
                    end else begin
                        n_level = LEVEL_W'(rel_diff);
                    end
                end
            endcase
        end else if (i_cmd.ctrl_we) begin
            // Only a change of the gate bit moves the phase.
            n_gate = i_cmd.value[0];
            if (i_cmd.value[0] != r_gate) begin
                n_phase = i_cmd.value[0] ? PH_ATTACK : PH_RELEASE;
            end
        end else if (i_cmd.ad_we) begin
            n_attack_step = i_step_hi;
            n_decay_step  = i_step_lo;
        end else if (i_cmd.sr_we) begin
            n_sustain      = i_cmd.value[DATA_W-1:4];
            n_release_step = i_step_lo;
        end
    end

    // Voice state, which also serves as this voice's part of the result word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_ATTACK;
            r_level        <= '0;
            r_gate         <= 1'b0;
            r_attack_step  <= '0;
            r_decay_step   <= '0;
            r_release_step <= '0;
            r_sustain      <= '0;
        end else if (i_en) begin
            r_phase        <= n_phase;
            r_level        <= n_level;
            r_gate         <= n_gate;
            r_attack_step  <= n_attack_step;
            r_decay_step   <= n_decay_step;
            r_release_step <= n_release_step;
            r_sustain      <= n_sustain;
        end
    end

    assign o_level = r_level;
    assign o_phase = r_phase;

endmodule
`default_nettype wire

// File: rtl/tvenv_chk.sv
// Port-level checks for the three-voice envelope block and their bind.
`default_nettype none
module tvenv_chk (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_out_valid,
    input  wire logic                          i_out_ready,
    input  wire logic [tvenv_pkg::LEVEL_W-1:0] i_level0,
    input  wire logic [tvenv_pkg::LEVEL_W-1:0] i_level1,
    input  wire logic [tvenv_pkg::LEVEL_W-1:0] i_level2,
    input  wire logic [1:0]                    i_phase0,
    input  wire logic [1:0]                    i_phase1,
    input  wire logic [1:0]                    i_phase2
);
    import tvenv_pkg::*;

    localparam logic [1:0] SUS = PH_SUSTAIN;

    // A stalled result word stays offered.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result word dropped while stalled");

    // Reset empties the result slot.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word present after reset");

    // Levels never pass full scale.
    a_level_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_level0 <= LEVEL_MAX) && (i_level1 <= LEVEL_MAX) &&
                         (i_level2 <= LEVEL_MAX)))
        else $error("envelope level above full scale");

    // In sustain a voice sits on a whole-number level.
    a_sustain_whole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            (((i_phase0 != SUS) || (i_level0[LEVEL_FRAC_BITS-1:0] == '0)) &&
             ((i_phase1 != SUS) || (i_level1[LEVEL_FRAC_BITS-1:0] == '0)) &&
             ((i_phase2 != SUS) || (i_level2[LEVEL_FRAC_BITS-1:0] == '0))))
        else $error("sustain phase with a fractional level");

endmodule

bind three_voice_adsr_envelope tvenv_chk u_tvenv_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_level0    (o_result.level_voice0),
    .i_level1    (o_result.level_voice1),
    .i_level2    (o_result.level_voice2),
    .i_phase0    (o_result.phase_voice0),
    .i_phase1    (o_result.phase_voice1),
    .i_phase2    (o_result.phase_voice2)
);
`default_nettype wire
